[rtl/bsf_pkg.sv]
package bsf_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 27;
	localparam int COEF_W             = 32;
	localparam int DELAY_W            = 48;
	localparam int GUARD_BITS         = 16;
	localparam int NUM_COEFS          = 5;
	localparam int CFG_IDX_W          = 3;
	localparam int STEP_W             = 3;

	localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sd134217728;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_MUL_B0 = 3'd1;
	localparam step_t STEP_MUL_B1 = 3'd2;
	localparam step_t STEP_MUL_B2 = 3'd3;
	localparam step_t STEP_MUL_A1 = 3'd4;
	localparam step_t STEP_MUL_A2 = 3'd5;
	localparam step_t STEP_WAIT   = 3'd6;
	localparam step_t STEP_COMMIT = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NO_IN,
		JC_OUT_FULL
	} jcond_t;

	typedef enum logic {
		SRC_X,
		SRC_Y
	} mul_src_t;

	typedef enum logic [2:0] {
		ASEL_ZERO,
		ASEL_D1,
		ASEL_D2,
		ASEL_ACC,
		ASEL_ACC2
	} asel_t;

	typedef enum logic [1:0] {
		DST_NONE,
		DST_ACC,
		DST_ACC2,
		DST_D2
	} dst_t;

	typedef struct packed {
		logic      take;
		jcond_t    jcond;
		step_t     jtarget;
		logic      mul_en;
		coef_sel_t mul_coef;
		mul_src_t  mul_src;
		asel_t     asel;
		logic      sub;
		dst_t      dst;
		logic      y_ld;
		logic      d1_ld;
		logic      out_ld;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		take:     1'b0,
		jcond:    JC_NONE,
		jtarget:  STEP_IDLE,
		mul_en:   1'b0,
		mul_coef: COEF_B0,
		mul_src:  SRC_X,
		asel:     ASEL_ZERO,
		sub:      1'b0,
		dst:      DST_NONE,
		y_ld:     1'b0,
		d1_ld:    1'b0,
		out_ld:   1'b0
	};

	// Microprogram: each product is summed next step; a2's at commit.
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (pc)
			STEP_IDLE: begin
				c.take    = 1'b1;
				c.jcond   = JC_NO_IN;
				c.jtarget = STEP_IDLE;
			end
			STEP_MUL_B0: begin
				c.mul_en   = 1'b1;
				c.mul_coef = COEF_B0;
				c.mul_src  = SRC_X;
			end
			STEP_MUL_B1: begin
				c.mul_en   = 1'b1;
				c.mul_coef = COEF_B1;
				c.mul_src  = SRC_X;
				c.asel     = ASEL_D1;
				c.dst      = DST_ACC;
			end
			STEP_MUL_B2: begin
				c.mul_en   = 1'b1;
				c.mul_coef = COEF_B2;
				c.mul_src  = SRC_X;
				c.y_ld     = 1'b1;
				c.asel     = ASEL_D2;
				c.dst      = DST_ACC;
			end
			STEP_MUL_A1: begin
				c.mul_en   = 1'b1;
				c.mul_coef = COEF_A1;
				c.mul_src  = SRC_Y;
				c.asel     = ASEL_ZERO;
				c.dst      = DST_ACC2;
			end
			STEP_MUL_A2: begin
				c.mul_en   = 1'b1;
				c.mul_coef = COEF_A2;
				c.mul_src  = SRC_Y;
				c.asel     = ASEL_ACC;
				c.sub      = 1'b1;
				c.dst      = DST_ACC;
			end
			STEP_WAIT: begin
				c.jcond   = JC_OUT_FULL;
				c.jtarget = STEP_WAIT;
			end
			STEP_COMMIT: begin
				c.asel    = ASEL_ACC2;
				c.sub     = 1'b1;
				c.dst     = DST_D2;
				c.d1_ld   = 1'b1;
				c.out_ld  = 1'b1;
				c.jcond   = JC_ALWAYS;
				c.jtarget = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

[rtl/bsf_if.sv]
interface bsf_in_if #(
	parameter int SAMPLE_WIDTH = bsf_pkg::SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface bsf_out_if #(
	parameter int SAMPLE_WIDTH = bsf_pkg::SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

[rtl/bsf_sequencer.sv]
module bsf_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_full,
	output logic            in_ready,
	output bsf_pkg::ctrl_t  ctrl
);

	bsf_pkg::step_t pc_q;
	bsf_pkg::step_t pc_next;
	logic           jump;

	always_comb begin
		ctrl     = bsf_pkg::ucode(pc_q);
		in_ready = ctrl.take;
		unique case (ctrl.jcond)
			bsf_pkg::JC_NONE:     jump = 1'b0;
			bsf_pkg::JC_ALWAYS:   jump = 1'b1;
			bsf_pkg::JC_NO_IN:    jump = !in_valid;
			bsf_pkg::JC_OUT_FULL: jump = out_full;
		endcase
		pc_next = jump ? ctrl.jtarget : pc_q + bsf_pkg::step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bsf_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[rtl/bsf_datapath.sv]
module bsf_datapath #(
	parameter int SAMPLE_WIDTH   = bsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bsf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsf_pkg::ctrl_t                      ctrl,
	input  logic                                x_ld,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	input  logic signed [bsf_pkg::COEF_W-1:0]   coef [bsf_pkg::NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0]      y
);

	localparam int COEF_W     = bsf_pkg::COEF_W;
	localparam int DELAY_W    = bsf_pkg::DELAY_W;
	localparam int GUARD      = bsf_pkg::GUARD_BITS;
	localparam int PROD_SHIFT = COEF_FRAC_BITS - GUARD;
	localparam int PROD_W     = COEF_W + SAMPLE_WIDTH;
	localparam int SH_W       = PROD_W - PROD_SHIFT;
	localparam int ACC_W      = ((SH_W > DELAY_W) ? SH_W : DELAY_W) + 2;
	localparam int RND_W      = ACC_W + 1 - GUARD;

	localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) <<< (GUARD - 1);

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        acc2_q;
	logic signed [DELAY_W-1:0]      d1_q;
	logic signed [DELAY_W-1:0]      d2_q;

	logic signed [COEF_W-1:0]       mul_c;
	logic signed [SAMPLE_WIDTH-1:0] mul_s;
	logic signed [ACC_W-1:0]        prod_sh;
	logic signed [ACC_W-1:0]        add_a;
	logic signed [ACC_W-1:0]        sum;
	logic signed [ACC_W:0]          acc_rnd;
	logic        [RND_W-1:0]        y_wide;
	logic        [RND_W-SAMPLE_WIDTH:0] y_top;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DELAY_W:0] top;
		top = v[ACC_W-1:DELAY_W-1];
		if (&top || ~|top) begin
			return v[DELAY_W-1:0];
		end
		return {v[ACC_W-1], {(DELAY_W-1){~v[ACC_W-1]}}};
	endfunction

	always_comb begin
		unique case (ctrl.mul_coef)
			bsf_pkg::COEF_B0: mul_c = coef[0];
			bsf_pkg::COEF_B1: mul_c = coef[1];
			bsf_pkg::COEF_B2: mul_c = coef[2];
			bsf_pkg::COEF_A1: mul_c = coef[3];
			bsf_pkg::COEF_A2: mul_c = coef[4];
			default:          mul_c = coef[0];
		endcase
		mul_s = (ctrl.mul_src == bsf_pkg::SRC_Y) ? y_q : x_q;

		prod_sh = {{(ACC_W-SH_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:PROD_SHIFT]};

		unique case (ctrl.asel)
			bsf_pkg::ASEL_ZERO: add_a = '0;
			bsf_pkg::ASEL_D1:   add_a = {{(ACC_W-DELAY_W){d1_q[DELAY_W-1]}}, d1_q};
			bsf_pkg::ASEL_D2:   add_a = {{(ACC_W-DELAY_W){d2_q[DELAY_W-1]}}, d2_q};
			bsf_pkg::ASEL_ACC:  add_a = acc_q;
			bsf_pkg::ASEL_ACC2: add_a = acc2_q;
			default:            add_a = '0;
		endcase
		sum = ctrl.sub ? add_a - prod_sh : add_a + prod_sh;

		// Round half up to the sample format, then saturate.
		acc_rnd = {acc_q[ACC_W-1], acc_q} + RND_HALF;
		y_wide  = acc_rnd[ACC_W:GUARD];
		y_top   = y_wide[RND_W-1:SAMPLE_WIDTH-1];
		if (&y_top || ~|y_top) begin
			y_sat = y_wide[SAMPLE_WIDTH-1:0];
		end else begin
			y_sat = {y_wide[RND_W-1], {(SAMPLE_WIDTH-1){~y_wide[RND_W-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (x_ld) begin
			x_q <= sample_in;
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_c * mul_s;
		end
		if (ctrl.y_ld) begin
			y_q <= y_sat;
		end
		if (ctrl.dst == bsf_pkg::DST_ACC) begin
			acc_q <= sum;
		end
		if (ctrl.dst == bsf_pkg::DST_ACC2) begin
			acc2_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (ctrl.d1_ld) begin
				d1_q <= sat_delay(acc_q);
			end
			if (ctrl.dst == bsf_pkg::DST_D2) begin
				d2_q <= sat_delay(sum);
			end
		end
	end

	assign y = y_q;

endmodule

[rtl/biquad_shelving_filter.sv]
// Second-order IIR section in transposed direct form II. Each accepted item on
// in_ch (a signed Q1.23 sample) gives one item on out_ch, rounded half up and
// saturated to the sample range. Coefficients b0, b1, b2, a1 and a2 are signed
// Q5.27 and are written at indexes 0 to 4 of the configuration port; after
// reset the section passes samples through unchanged. A sample is taken in the
// idle step of the eight-step microprogram and runs through the multiply steps,
// the wait step and the commit step, which loads the output register; no new
// sample is taken before that. The microprogram drives the single shared
// coefficient-by-sample multiplier five times per sample. The result sits in
// an output register, so the next sample is accepted while it waits to be
// taken; that sample then holds in the wait step until that result is taken.
module biquad_shelving_filter #(
	parameter int SAMPLE_WIDTH   = bsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bsf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bsf_in_if.sink                            in_ch,
	bsf_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsf_pkg::COEF_W-1:0]        cfg_data
);

	logic signed [bsf_pkg::COEF_W-1:0] coef_q [bsf_pkg::NUM_COEFS];
	logic                              out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]    out_data_q;
	logic signed [SAMPLE_WIDTH-1:0]    y;
	logic                              in_ready;
	logic                              out_full;
	bsf_pkg::ctrl_t                    ctrl;

	assign out_full      = out_valid_q && !out_ch.ready;
	assign in_ch.ready   = in_ready;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= bsf_pkg::COEF_B0_RESET;
			for (int i = 1; i < bsf_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < bsf_pkg::CFG_IDX_W'(bsf_pkg::NUM_COEFS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_ld) begin
			out_data_q <= y;
		end
	end

	bsf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.out_full (out_full),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	bsf_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.x_ld      (in_ch.valid && in_ready),
		.sample_in (in_ch.sample_in),
		.coef      (coef_q),
		.y         (y)
	);

endmodule

[verif/biquad_shelving_filter_checker.sv]
`timescale 1ns / 100ps

module biquad_shelving_filter_checker
	import bsf_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] out_sample,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]              cfg_data,
	output int                             pending,
	output int                             checked,
	output int                             fail_count
);

	localparam int PROD_SHIFT = COEF_FRAC_BITS - GUARD_BITS;

	logic signed [COEF_W-1:0]       coef_q [NUM_COEFS];
	logic signed [DELAY_W-1:0]      delay_one_q;
	logic signed [DELAY_W-1:0]      delay_two_q;
	logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
	logic signed [SAMPLE_WIDTH-1:0] want;

	function automatic longint scale_term(input longint c, input longint s);
		return (c * s) >>> PROD_SHIFT;
	endfunction

	function automatic longint saturate(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// Advances the filter state by one sample and returns the output sample.
	function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
		input logic signed [SAMPLE_WIDTH-1:0] x_in
	);
		longint x;
		longint y;
		longint n1;
		longint n2;
		x = x_in;
		y = scale_term(coef_q[COEF_B0], x) + delay_one_q;
		y = saturate((y + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS, SAMPLE_WIDTH);
		n1 = scale_term(coef_q[COEF_B1], x) - scale_term(coef_q[COEF_A1], y) + delay_two_q;
		n2 = scale_term(coef_q[COEF_B2], x) - scale_term(coef_q[COEF_A2], y);
		delay_one_q = saturate(n1, DELAY_W);
		delay_two_q = saturate(n2, DELAY_W);
		return y[SAMPLE_WIDTH-1:0];
	endfunction

	task automatic report(input string msg);
		$display("checker: %s", msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] = '0;
			end
			coef_q[COEF_B0] = COEF_B0_RESET;
			delay_one_q = '0;
			delay_two_q = '0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			if (cfg_we && cfg_index < NUM_COEFS) begin
				coef_q[cfg_index] = cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_samples.push_back(filter_sample(in_sample));
			end
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report($sformatf("output item %0d arrived with no sample waiting", out_sample));
				end else begin
					want = expected_samples.pop_front();
					if (out_sample !== want) begin
						report($sformatf("sample_out of item %0d: expected %0d, got %0d",
							checked, want, out_sample));
					end
					checked++;
				end
			end
			pending <= expected_samples.size();
		end
	end

endmodule

[verif/biquad_shelving_filter_test.sv]
`timescale 1ns / 100ps

module biquad_shelving_filter_test;
	import bsf_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(NUM_COEFS);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
	localparam logic [COEF_W-1:0] COEF_ONE  = COEF_B0_RESET;
	localparam logic [COEF_W-1:0] COEF_TWO  = COEF_B0_RESET << 1;
	localparam logic [COEF_W-1:0] COEF_HALF = COEF_B0_RESET >> 1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	bit                   steady;
	int                   settings;
	int                   pending;
	int                   checked;
	int                   fail_count;

	bsf_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
	bsf_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

	biquad_shelving_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	biquad_shelving_filter_checker #(.SAMPLE_WIDTH(SW)) response_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_sample  (in_ch.sample_in),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_sample (out_ch.sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.checked    (checked),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 55) begin
			return 0;
		end
		if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int signed_range(input int lim);
		int v;
		v = $urandom_range(0, 2 * lim);
		return v - lim;
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		int                   pick;
		logic signed [SW-1:0] s;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			s = SW'($urandom);
		end else if (pick < 8) begin
			s = SW'(signed_range(512));
		end else if (pick == 8) begin
			s = SAMPLE_MAX;
		end else begin
			s = SAMPLE_MIN;
		end
		return s;
	endfunction

	initial begin : ready_gen
		bit rdy;
		int hold;
		rdy = 1'b0;
		hold = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (steady) begin
				rdy = 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if (rdy) begin
				hold = pick_gap();
				if (hold > 0) begin
					rdy = 1'b0;
				end
			end else begin
				rdy = 1'b1;
				hold = $urandom_range(1, 30);
			end
			out_ch.ready <= rdy;
		end
	end

	task automatic send_sample(input logic signed [SW-1:0] x);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= x;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_coefs(
		input logic [COEF_W-1:0] b0,
		input logic [COEF_W-1:0] b1,
		input logic [COEF_W-1:0] b2,
		input logic [COEF_W-1:0] a1,
		input logic [COEF_W-1:0] a2,
		input bit                with_spare
	);
		wait_results();
		write_coef(COEF_B0, b0);
		write_coef(COEF_B1, b1);
		write_coef(COEF_B2, b2);
		write_coef(COEF_A1, a1);
		write_coef(COEF_A2, a2);
		if (with_spare) begin
			write_coef(CFG_SPARE_FIRST, $urandom);
			write_coef(CFG_SPARE_LAST, $urandom);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// A stable shelf-like section: |a2| < 1 and |a1| < 1 + a2.
	task automatic load_shelf();
		int a2;
		int lim;
		a2 = $urandom_range(0, 127506841);
		lim = ((134217728 + a2) / 20) * 19;
		load_coefs($urandom_range(67108864, 268435456), signed_range(1 << 29),
			signed_range(1 << 28), signed_range(lim), a2, 1'b0);
	endtask

	task automatic send_corners();
		logic signed [SW-1:0] corner [8];
		corner = '{'0, SW'(1), SW'(-1), SAMPLE_MAX, SAMPLE_MIN, 24'h555555, 24'haaaaaa,
			24'h400000};
		foreach (corner[i]) begin
			send_sample(corner[i]);
		end
	endtask

	task automatic send_random(input int n, input bit pause_midway);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2) begin
				wait_results();
			end
			send_sample(rand_sample());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		settings = 1;
		in_ch.valid <= 1'b0;
		in_ch.sample_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= COEF_B0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_corners();
		load_coefs(COEF_TWO, '0, '0, '0, '0, 1'b0);
		send_corners();
		load_coefs(COEF_HALF, '0, '0, '0, '0, 1'b0);
		send_sample(1);
		send_sample(-1);
		send_sample(3);
		send_sample(-3);
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
		send_corners();

		send_random(150, 1'b0);
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
		send_random(150, 1'b0);
		load_shelf();
		send_random(250, 1'b0);
		load_shelf();
		send_random(250, 1'b1);
		load_shelf();
		steady = 1'b1;
		send_random(250, 1'b0);
		steady = 1'b0;
		load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
		send_random(150, 1'b0);
		load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
		send_random(150, 1'b0);
		load_coefs('0, '0, '0, '0, '0, 1'b1);
		send_random(100, 1'b0);
		load_coefs(COEF_ONE, '0, '0, '0, '0, 1'b0);
		steady = 1'b1;
		send_random(100, 1'b0);
		wait_results();

		$display("covered %0d samples over %0d coefficient settings:", checked, settings);
		$display("bypass, gain and rounding, full-scale, stable shelves, random and zero sets");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
